FILE: sv/i2cbl_pkg.sv
`default_nettype none

package i2cbl_pkg;

  // width of the phase delay counter
  localparam int DELAY_BITS = 16;

  // field widths
  localparam int ACTION_W = 3;
  localparam int BYTE_W   = 8;
  localparam int PTICK_W  = 16;
  localparam int PHASE_W  = 3;
  localparam int BITCNT_W = 3;
  localparam int SERR_W   = 2;

  // stream widths (whole bytes)
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // reset value of the phase length register
  localparam logic [PTICK_W-1:0] PTICK_RESET = PTICK_W'(58);

  // action codes
  localparam logic [ACTION_W-1:0] ACT_NONE      = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_START     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_STOP      = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_WRITE     = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ_ACK  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_READ_NACK = 3'd5;

  // start outcome codes
  localparam logic [SERR_W-1:0] SERR_OK       = 2'd0;
  localparam logic [SERR_W-1:0] SERR_BUS_BUSY = 2'd1;
  localparam logic [SERR_W-1:0] SERR_STUCK_HI = 2'd2;

  // one result, scl in the lowest bit
  typedef struct packed {
    logic [SERR_W-1:0] start_error;
    logic              ack_ok;
    logic [BYTE_W-1:0] rx_byte;
    logic              done_res;
    logic              busy_res;
    logic              sda_level;
    logic              scl_level;
  } i2cbl_res_t;

  // ticks per bus phase: zero counts as one, saturates at the counter range
  function automatic logic [DELAY_BITS-1:0] phase_len(input logic [PTICK_W-1:0] ticks);
    logic [31:0] t;
    logic [31:0] maxv;
    maxv = 32'({DELAY_BITS{1'b1}});
    t    = 32'(ticks);
    if (t == 32'd0) t = 32'd1;
    if (t > maxv) t = maxv;
    return t[DELAY_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/i2cbl_step.sv
`default_nettype none

module i2cbl_step (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 step_en,
  input  wire logic [i2cbl_pkg::ACTION_W-1:0]       action,
  input  wire logic [i2cbl_pkg::BYTE_W-1:0]         data_byte,
  input  wire logic                                 sda_in,
  input  wire logic [i2cbl_pkg::PTICK_W-1:0]        phase_ticks,
  output i2cbl_pkg::i2cbl_res_t                     res
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_STOP, ST_WRITE, ST_READ_ACK, ST_READ_NACK
  } cmd_state_t;

  cmd_state_t                             cmd_r, cmd_nxt;
  logic [i2cbl_pkg::PHASE_W-1:0]          phase_r, phase_nxt;
  logic [i2cbl_pkg::BITCNT_W-1:0]         bcnt_r, bcnt_nxt;
  logic [i2cbl_pkg::DELAY_BITS-1:0]       dcnt_r, dcnt_nxt, dcnt_dec;
  logic [i2cbl_pkg::BYTE_W-1:0]           shift_r, shift_nxt;
  logic                                   scl_r, scl_nxt;
  logic                                   sda_r, sda_nxt;
  logic                                   ack_r, ack_nxt;
  logic [i2cbl_pkg::SERR_W-1:0]           serr_r, serr_nxt;
  logic [i2cbl_pkg::BYTE_W-1:0]           rx_r, rx_nxt;
  logic                                   finish;
  logic                                   enter;
  logic                                   done;

  // next state for one tick
  always_comb begin
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    bcnt_nxt  = bcnt_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    serr_nxt  = serr_r;
    rx_nxt    = rx_r;
    finish    = 1'b0;
    enter     = 1'b0;
    done      = 1'b0;
    dcnt_dec  = (dcnt_r != '0) ? dcnt_r - 1'b1 : '0;
    dcnt_nxt  = dcnt_r;

    if (cmd_r != ST_IDLE) begin
      dcnt_nxt = dcnt_dec;
      if (dcnt_dec == '0) begin
        // end of the current phase
        case (cmd_r)
          ST_START: begin
            if (phase_r == 3'd0) begin
              if (!sda_in) begin
                serr_nxt = i2cbl_pkg::SERR_BUS_BUSY;
                finish   = 1'b1;
              end else begin
                phase_nxt = 3'd1;
              end
            end else if (phase_r == 3'd1) begin
              if (sda_in) begin
                serr_nxt = i2cbl_pkg::SERR_STUCK_HI;
                finish   = 1'b1;
              end else begin
                phase_nxt = 3'd2;
              end
            end else begin
              serr_nxt = i2cbl_pkg::SERR_OK;
              finish   = 1'b1;
            end
          end
          ST_STOP: begin
            if (phase_r >= 3'd3) finish = 1'b1;
            else phase_nxt = phase_r + 1'b1;
          end
          ST_WRITE: begin
            if (phase_r == 3'd1) begin
              shift_nxt = {shift_r[i2cbl_pkg::BYTE_W-2:0], 1'b0};
              phase_nxt = 3'd2;
            end else if (phase_r == 3'd2) begin
              if (bcnt_r != 3'd7) begin
                bcnt_nxt  = bcnt_r + 1'b1;
                phase_nxt = 3'd0;
              end else begin
                phase_nxt = 3'd3;
              end
            end else if (phase_r >= 3'd5) begin
              ack_nxt = ~sda_in;
              scl_nxt = 1'b0;
              finish  = 1'b1;
            end else begin
              phase_nxt = phase_r + 1'b1;
            end
          end
          ST_READ_ACK, ST_READ_NACK: begin
            if (phase_r == 3'd1) begin
              shift_nxt = {shift_r[i2cbl_pkg::BYTE_W-2:0], sda_in};
              if (bcnt_r != 3'd7) begin
                bcnt_nxt  = bcnt_r + 1'b1;
                phase_nxt = 3'd0;
              end else begin
                rx_nxt    = {shift_r[i2cbl_pkg::BYTE_W-2:0], sda_in};
                phase_nxt = 3'd2;
              end
            end else if (phase_r >= 3'd5) begin
              finish = 1'b1;
            end else begin
              phase_nxt = phase_r + 1'b1;
            end
          end
          default: finish = 1'b1;
        endcase
        if (finish) begin
          cmd_nxt   = ST_IDLE;
          phase_nxt = '0;
          bcnt_nxt  = '0;
          done      = 1'b1;
        end else begin
          enter = 1'b1;
        end
      end
    end else begin
      // command decode while idle
      unique case (action)
        i2cbl_pkg::ACT_START:     cmd_nxt = ST_START;
        i2cbl_pkg::ACT_STOP:      cmd_nxt = ST_STOP;
        i2cbl_pkg::ACT_WRITE:     cmd_nxt = ST_WRITE;
        i2cbl_pkg::ACT_READ_ACK:  cmd_nxt = ST_READ_ACK;
        i2cbl_pkg::ACT_READ_NACK: cmd_nxt = ST_READ_NACK;
        default:                  cmd_nxt = ST_IDLE;
      endcase
      if (cmd_nxt != ST_IDLE) begin
        phase_nxt = '0;
        bcnt_nxt  = '0;
        shift_nxt = (cmd_nxt == ST_WRITE) ? data_byte : '0;
        enter     = 1'b1;
      end
    end

    // line drive at the start of the next phase
    if (enter) begin
      case (cmd_nxt)
        ST_START: begin
          if (phase_nxt == 3'd0) begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
          end else begin
            sda_nxt = 1'b0;
          end
        end
        ST_STOP: begin
          if (phase_nxt == 3'd0)      scl_nxt = 1'b0;
          else if (phase_nxt == 3'd1) sda_nxt = 1'b0;
          else if (phase_nxt == 3'd2) scl_nxt = 1'b1;
          else                        sda_nxt = 1'b1;
        end
        ST_WRITE: begin
          if (phase_nxt == 3'd0 || phase_nxt == 3'd3) scl_nxt = 1'b0;
          else if (phase_nxt == 3'd1) sda_nxt = shift_nxt[i2cbl_pkg::BYTE_W-1];
          else if (phase_nxt == 3'd4) sda_nxt = 1'b1;
          else                        scl_nxt = 1'b1;
        end
        default: begin
          if (phase_nxt == 3'd0) begin
            if (bcnt_nxt == '0) sda_nxt = 1'b1;
            scl_nxt = 1'b0;
          end else if (phase_nxt == 3'd1 || phase_nxt == 3'd4) begin
            scl_nxt = 1'b1;
          end else if (phase_nxt == 3'd3) begin
            sda_nxt = (cmd_nxt == ST_READ_NACK);
          end else begin
            scl_nxt = 1'b0;
          end
        end
      endcase
      dcnt_nxt = i2cbl_pkg::phase_len(phase_ticks);
    end
  end

  // state registers, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= ST_IDLE;
      phase_r <= '0;
      bcnt_r  <= '0;
      dcnt_r  <= '0;
      shift_r <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      serr_r  <= i2cbl_pkg::SERR_OK;
      rx_r    <= '0;
    end else if (step_en) begin
      cmd_r   <= cmd_nxt;
      phase_r <= phase_nxt;
      bcnt_r  <= bcnt_nxt;
      dcnt_r  <= dcnt_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      serr_r  <= serr_nxt;
      rx_r    <= rx_nxt;
    end
  end

  // result of this tick
  assign res.scl_level   = scl_nxt;
  assign res.sda_level   = sda_nxt;
  assign res.busy_res    = (cmd_nxt != ST_IDLE);
  assign res.done_res    = done;
  assign res.rx_byte     = rx_nxt;
  assign res.ack_ok      = ack_nxt;
  assign res.start_error = serr_nxt;

  // idle leaves no phase or bit position behind
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r == ST_IDLE) |-> (phase_r == '0 && bcnt_r == '0))
    else $error("idle with phase or bit count left over");

  // a running command always has a phase timer loaded
  a_busy_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r != ST_IDLE) |-> (dcnt_r != '0))
    else $error("command running with empty phase timer");

  // no command goes past its sixth phase
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= 3'd5)
    else $error("phase out of range");

  // bit position moves only in byte transfers
  a_bcnt_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r == ST_START || cmd_r == ST_STOP) |-> (bcnt_r == '0))
    else $error("bit count moved outside a byte transfer");

  // a held tick leaves the state alone
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> ($stable(cmd_r) && $stable(dcnt_r) && $stable(phase_r)))
    else $error("state moved without a tick");

endmodule

`default_nettype wire

FILE: sv/i2cbl_out_reg.sv
`default_nettype none

module i2cbl_out_reg (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   res_valid,
  output logic                                        res_ready,
  input  wire i2cbl_pkg::i2cbl_res_t                  res,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [i2cbl_pkg::OUT_TDATA_W-1:0]           out_tdata
);

  logic                   valid_r;
  i2cbl_pkg::i2cbl_res_t  data_r;
  logic                   load;

  // free when empty or when the held result leaves this cycle
  assign res_ready = !valid_r || out_tready;
  assign load      = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = i2cbl_pkg::OUT_TDATA_W'(data_r);

endmodule

`default_nettype wire

FILE: sv/i2c_bit_level_master_core.sv
// channel  | direction | tdata fields, lowest bit up
// ---------+-----------+-----------------------------------------------------------
// in_      | slave     | action[2:0], data_byte[10:3], sda_in[11], zero[15:12]
// out_     | master    | scl_level[0], sda_level[1], busy_res[2], done_res[3],
//          |           | rx_byte[11:4], ack_ok[12], start_error[14:13], zero[15]
// cfg_     | write     | phase_ticks[15:0]
//
// one tick item per clock unless out_ stalls; each accepted tick gives exactly one registered result
// the whole tick update is one pass of logic between the state registers and the
// output register; bus timing is paced by the phase counter, not by the clock
// rst_n is synchronous: lines released, idle, phase_ticks back to 58
// a stalled output holds its result and stops new ticks until it is taken
// cfg_ready is always high; a new phase_ticks applies from the next bus phase
`default_nettype none

module i2c_bit_level_master_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // action[2:0], data_byte[10:3], sda_in[11], zero[15:12]
  input  wire logic [i2cbl_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // scl_level[0], sda_level[1], busy_res[2], done_res[3], rx_byte[11:4],
  // ack_ok[12], start_error[14:13], zero[15]
  output logic [i2cbl_pkg::OUT_TDATA_W-1:0]           out_tdata,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [i2cbl_pkg::PTICK_W-1:0]          cfg_data
);

  logic [i2cbl_pkg::PTICK_W-1:0]  ptick_r;
  logic                           in_xfer;
  i2cbl_pkg::i2cbl_res_t          step_res;

  // phase length register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptick_r <= i2cbl_pkg::PTICK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ptick_r <= cfg_data;
    end
  end

  // input transfer
  assign in_xfer = in_tvalid && in_tready;

  i2cbl_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (in_xfer),
    .action      (in_tdata[2:0]),
    .data_byte   (in_tdata[10:3]),
    .sda_in      (in_tdata[11]),
    .phase_ticks (ptick_r),
    .res         (step_res)
  );

  i2cbl_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (in_tvalid),
    .res_ready  (in_tready),
    .res        (step_res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

FILE: sim/i2c_bit_level_master_core_tb.sv
`timescale 1ns / 100ps

module i2c_bit_level_master_core_tb;

  // action codes the block ignores like none
  localparam logic [i2cbl_pkg::ACTION_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [i2cbl_pkg::ACTION_W-1:0] ACT_RSVD7 = 3'd7;

  // cycles without any transfer before the run is given up
  localparam int IDLE_LIMIT = 2000;

  // how the far end answers on sda
  typedef enum {SL_NORM, SL_LOW, SL_HIGH, SL_NOISE} slave_t;
  // which fields of the last result of a step are typed in
  typedef enum {EXP_PREDICT, EXP_IDLE, EXP_DONE} typed_t;

  typedef struct {
    int                                cfg_pre;
    int                                cfg_mid;
    logic [i2cbl_pkg::ACTION_W-1:0]    act;
    logic [i2cbl_pkg::BYTE_W-1:0]      db;
    slave_t                            mode;
    typed_t                            typed;
    logic [i2cbl_pkg::BYTE_W-1:0]      rx;
    logic                              ack;
    logic [i2cbl_pkg::SERR_W-1:0]      serr;
  } step_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_tvalid = 1'b0;
  logic                                 in_tready;
  // action[2:0], data_byte[10:3], sda_in[11], zero[15:12]
  logic [i2cbl_pkg::IN_TDATA_W-1:0]     in_tdata = '0;
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  // scl_level[0], sda_level[1], busy_res[2], done_res[3], rx_byte[11:4],
  // ack_ok[12], start_error[14:13], zero[15]
  logic [i2cbl_pkg::OUT_TDATA_W-1:0]    out_tdata;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [i2cbl_pkg::PTICK_W-1:0]        cfg_data = '0;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int ticks_sent = 0;

  int idle_tab[4]  = '{0, 70, 0, 35};
  int stall_tab[4] = '{0, 0, 70, 35};
  int len_tab[4]   = '{1, 0, 2, 1};

  i2cbl_pkg::i2cbl_res_t line_status_q[$];

  // directed steps: one command (or one idle tick) each
  step_t directed_steps[18] = '{
    '{-1, -1, i2cbl_pkg::ACT_NONE, 8'h00, SL_NORM, EXP_IDLE, 8'h00, 1'b0,
      i2cbl_pkg::SERR_OK},
    '{-1, -1, ACT_RSVD6, 8'hFF, SL_NORM, EXP_IDLE, 8'h00, 1'b0, i2cbl_pkg::SERR_OK},
    '{-1, -1, ACT_RSVD7, 8'h00, SL_NORM, EXP_IDLE, 8'h00, 1'b0, i2cbl_pkg::SERR_OK},
    '{0,  -1, i2cbl_pkg::ACT_START, 8'h00, SL_LOW, EXP_DONE, 8'h00, 1'b0,
      i2cbl_pkg::SERR_BUS_BUSY},
    '{-1, -1, i2cbl_pkg::ACT_START, 8'h00, SL_HIGH, EXP_DONE, 8'h00, 1'b0,
      i2cbl_pkg::SERR_STUCK_HI},
    '{-1, -1, i2cbl_pkg::ACT_START, 8'h00, SL_NORM, EXP_DONE, 8'h00, 1'b0,
      i2cbl_pkg::SERR_OK},
    '{-1, -1, i2cbl_pkg::ACT_WRITE, 8'hFF, SL_LOW, EXP_DONE, 8'h00, 1'b1,
      i2cbl_pkg::SERR_OK},
    '{-1, -1, i2cbl_pkg::ACT_WRITE, 8'h00, SL_HIGH, EXP_DONE, 8'h00, 1'b0,
      i2cbl_pkg::SERR_OK},
    '{-1, -1, i2cbl_pkg::ACT_WRITE, 8'hA5, SL_LOW, EXP_DONE, 8'h00, 1'b1,
      i2cbl_pkg::SERR_OK},
    '{-1, -1, i2cbl_pkg::ACT_READ_ACK, 8'hFF, SL_HIGH, EXP_DONE, 8'hFF, 1'b1,
      i2cbl_pkg::SERR_OK},
    '{-1, -1, i2cbl_pkg::ACT_READ_NACK, 8'hFF, SL_LOW, EXP_DONE, 8'h00, 1'b1,
      i2cbl_pkg::SERR_OK},
    '{-1, -1, i2cbl_pkg::ACT_READ_ACK, 8'h00, SL_NORM, EXP_PREDICT, 8'h00, 1'b0,
      i2cbl_pkg::SERR_OK},
    '{-1, -1, i2cbl_pkg::ACT_STOP, 8'h00, SL_NORM, EXP_PREDICT, 8'h00, 1'b0,
      i2cbl_pkg::SERR_OK},
    '{1,  -1, i2cbl_pkg::ACT_START, 8'h00, SL_NORM, EXP_PREDICT, 8'h00, 1'b0,
      i2cbl_pkg::SERR_OK},
    '{65535, -1, ACT_RSVD6, 8'h00, SL_NORM, EXP_PREDICT, 8'h00, 1'b0,
      i2cbl_pkg::SERR_OK},
    '{1,   2, i2cbl_pkg::ACT_WRITE, 8'h3C, SL_NORM, EXP_PREDICT, 8'h00, 1'b0,
      i2cbl_pkg::SERR_OK},
    '{3,  -1, i2cbl_pkg::ACT_STOP, 8'h00, SL_NORM, EXP_PREDICT, 8'h00, 1'b0,
      i2cbl_pkg::SERR_OK},
    '{1,  -1, i2cbl_pkg::ACT_READ_NACK, 8'h00, SL_NORM, EXP_PREDICT, 8'h00, 1'b0,
      i2cbl_pkg::SERR_OK}
  };

  i2c_bit_level_master_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bus master state as the block should hold it
  logic [i2cbl_pkg::PTICK_W-1:0]    phase_len_reg = i2cbl_pkg::PTICK_RESET;
  logic [4:0]                       bus_phase = '0;
  logic [i2cbl_pkg::ACTION_W-1:0]   bus_cmd = i2cbl_pkg::ACT_NONE;
  logic [3:0]                       bit_idx = '0;
  logic [i2cbl_pkg::DELAY_BITS-1:0] hold_cnt = '0;
  logic [i2cbl_pkg::BYTE_W-1:0]     shifter = '0;
  logic                             scl_drv = 1'b1;
  logic                             sda_drv = 1'b1;
  logic                             ack_seen = 1'b0;
  logic [i2cbl_pkg::SERR_W-1:0]     start_err = i2cbl_pkg::SERR_OK;
  logic [i2cbl_pkg::BYTE_W-1:0]     rx_last = '0;

  // drive of the new phase, then reload the phase counter
  function automatic void enter_phase();
    longint unsigned len;
    longint unsigned cap;
    case (bus_cmd)
      i2cbl_pkg::ACT_START: begin
        if (bus_phase == 0) begin
          sda_drv = 1'b1;
          scl_drv = 1'b1;
        end else sda_drv = 1'b0;
      end
      i2cbl_pkg::ACT_STOP: begin
        if (bus_phase == 0) scl_drv = 1'b0;
        else if (bus_phase == 1) sda_drv = 1'b0;
        else if (bus_phase == 2) scl_drv = 1'b1;
        else sda_drv = 1'b1;
      end
      i2cbl_pkg::ACT_WRITE: begin
        if (bus_phase == 0 || bus_phase == 3) scl_drv = 1'b0;
        else if (bus_phase == 1) sda_drv = shifter[7];
        else if (bus_phase == 4) sda_drv = 1'b1;
        else scl_drv = 1'b1;
      end
      default: begin
        if (bus_phase == 0) begin
          if (bit_idx == 0) sda_drv = 1'b1;
          scl_drv = 1'b0;
        end else if (bus_phase == 1 || bus_phase == 4) scl_drv = 1'b1;
        else if (bus_phase == 3) sda_drv = (bus_cmd == i2cbl_pkg::ACT_READ_NACK);
        else scl_drv = 1'b0;
      end
    endcase
    // zero counts as one, anything above the counter range saturates
    cap = (64'd1 << i2cbl_pkg::DELAY_BITS) - 1;
    len = (phase_len_reg == '0) ? 1 : longint'(phase_len_reg);
    if (len > cap) len = cap;
    hold_cnt = len[i2cbl_pkg::DELAY_BITS-1:0];
  endfunction

  // close the current phase; 1 when the command is over
  function automatic logic end_phase(input logic s);
    case (bus_cmd)
      i2cbl_pkg::ACT_START: begin
        if (bus_phase == 0) begin
          if (!s) begin
            start_err = i2cbl_pkg::SERR_BUS_BUSY;
            return 1'b1;
          end
          bus_phase = 1;
        end else if (bus_phase == 1) begin
          if (s) begin
            start_err = i2cbl_pkg::SERR_STUCK_HI;
            return 1'b1;
          end
          bus_phase = 2;
        end else begin
          start_err = i2cbl_pkg::SERR_OK;
          return 1'b1;
        end
        return 1'b0;
      end
      i2cbl_pkg::ACT_STOP: begin
        if (bus_phase >= 3) return 1'b1;
        bus_phase++;
        return 1'b0;
      end
      i2cbl_pkg::ACT_WRITE: begin
        if (bus_phase == 1) begin
          shifter = shifter << 1;
          bus_phase = 2;
        end else if (bus_phase == 2) begin
          if (bit_idx < 7) begin
            bit_idx++;
            bus_phase = 0;
          end else bus_phase = 3;
        end else if (bus_phase >= 5) begin
          ack_seen = !s;
          scl_drv = 1'b0;
          return 1'b1;
        end else bus_phase++;
        return 1'b0;
      end
      default: begin
        if (bus_phase == 1) begin
          shifter = {shifter[6:0], s};
          if (bit_idx < 7) begin
            bit_idx++;
            bus_phase = 0;
          end else begin
            rx_last = shifter;
            bus_phase = 2;
          end
        end else if (bus_phase >= 5) return 1'b1;
        else bus_phase++;
        return 1'b0;
      end
    endcase
  endfunction

  // one tick of the master and the result it gives
  function automatic i2cbl_pkg::i2cbl_res_t master_tick(
      input logic [i2cbl_pkg::ACTION_W-1:0] act,
      input logic [i2cbl_pkg::BYTE_W-1:0] db, input logic s);
    i2cbl_pkg::i2cbl_res_t r;
    logic fin;
    fin = 1'b0;
    if (bus_cmd != i2cbl_pkg::ACT_NONE) begin
      if (hold_cnt > 0) hold_cnt--;
      if (hold_cnt == 0) begin
        if (end_phase(s)) begin
          bus_cmd = i2cbl_pkg::ACT_NONE;
          bus_phase = 0;
          bit_idx = 0;
          fin = 1'b1;
        end else enter_phase();
      end
    end else if (act >= i2cbl_pkg::ACT_START && act <= i2cbl_pkg::ACT_READ_NACK) begin
      bus_cmd = act;
      bus_phase = 0;
      bit_idx = 0;
      shifter = (act == i2cbl_pkg::ACT_WRITE) ? db : '0;
      enter_phase();
    end
    r.scl_level   = scl_drv;
    r.sda_level   = sda_drv;
    r.busy_res    = (bus_cmd != i2cbl_pkg::ACT_NONE);
    r.done_res    = fin;
    r.rx_byte     = rx_last;
    r.ack_ok      = ack_seen;
    r.start_error = start_err;
    return r;
  endfunction

  // sda on the bus: master drive wired with the far end, or forced by the mode
  function automatic logic slave_sda(input slave_t mode);
    logic pull;
    case (mode)
      SL_LOW:   return 1'b0;
      SL_HIGH:  return 1'b1;
      SL_NOISE: return 1'($urandom_range(0, 1));
      default: begin
        pull = 1'b0;
        if (bus_cmd == i2cbl_pkg::ACT_READ_ACK || bus_cmd == i2cbl_pkg::ACT_READ_NACK)
          pull = 1'($urandom_range(0, 1));
        else if (bus_cmd == i2cbl_pkg::ACT_WRITE && bus_phase == 5)
          pull = ($urandom_range(0, 3) != 0);
        return sda_drv & !pull;
      end
    endcase
  endfunction

  function automatic logic [i2cbl_pkg::ACTION_W-1:0] idle_act();
    case ($urandom_range(0, 2))
      0:       return i2cbl_pkg::ACT_NONE;
      1:       return ACT_RSVD6;
      default: return ACT_RSVD7;
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // one tick transfer on the input side, with random sender gaps
  task automatic send_tick(input logic [i2cbl_pkg::ACTION_W-1:0] act,
                           input logic [i2cbl_pkg::BYTE_W-1:0] db, input logic sda);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, sda, db, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    line_status_q.push_back(master_tick(act, db, sda));
    ticks_sent++;
  endtask

  // phase length write, only once every result is out
  task automatic write_ptick(input logic [i2cbl_pkg::PTICK_W-1:0] len);
    in_tvalid <= 1'b0;
    while (line_status_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    phase_len_reg = len;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // issue a command and tick until it completes; busy ticks carry stray actions
  task automatic run_command(input logic [i2cbl_pkg::ACTION_W-1:0] act,
                             input logic [i2cbl_pkg::BYTE_W-1:0] db,
                             input slave_t mode, input int mid_len);
    send_tick(act, db, slave_sda(mode));
    if (mid_len >= 0 && bus_cmd != i2cbl_pkg::ACT_NONE)
      write_ptick(i2cbl_pkg::PTICK_W'(mid_len));
    while (bus_cmd != i2cbl_pkg::ACT_NONE)
      send_tick(i2cbl_pkg::ACTION_W'($urandom_range(0, 7)),
                i2cbl_pkg::BYTE_W'($urandom), slave_sda(mode));
  endtask

  // mostly well-formed transactions, some lone commands and bus noise
  task automatic random_traffic(input int n_ticks);
    logic [i2cbl_pkg::ACTION_W-1:0] plan[$];
    logic [i2cbl_pkg::ACTION_W-1:0] data_cmds[3];
    slave_t mode;
    int stop_at;
    data_cmds = '{i2cbl_pkg::ACT_WRITE, i2cbl_pkg::ACT_READ_ACK, i2cbl_pkg::ACT_READ_NACK};
    mode = SL_NORM;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      if (plan.size() == 0) begin
        if ($urandom_range(0, 5) == 0)
          write_ptick(i2cbl_pkg::PTICK_W'($urandom_range(0, 2)));
        mode = ($urandom_range(0, 9) == 0) ? SL_NOISE : SL_NORM;
        if ($urandom_range(0, 7) == 0) begin
          plan.push_back(i2cbl_pkg::ACTION_W'($urandom_range(i2cbl_pkg::ACT_START,
                                                             i2cbl_pkg::ACT_READ_NACK)));
        end else begin
          plan.push_back(i2cbl_pkg::ACT_START);
          plan.push_back(i2cbl_pkg::ACT_WRITE);
          repeat ($urandom_range(1, 3)) plan.push_back(data_cmds[$urandom_range(0, 2)]);
          plan.push_back(i2cbl_pkg::ACT_STOP);
        end
      end
      repeat ($urandom_range(0, 2))
        send_tick(idle_act(), i2cbl_pkg::BYTE_W'($urandom), slave_sda(mode));
      run_command(plan.pop_front(), i2cbl_pkg::BYTE_W'($urandom), mode,
                  ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2)) : -1);
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // result transfers against the oldest expectation
  always @(posedge clk) begin
    i2cbl_pkg::i2cbl_res_t want;
    i2cbl_pkg::i2cbl_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      if (line_status_q.size() == 0) begin
        $error("result with no expectation pending: %h", out_tdata);
        mismatches++;
      end else begin
        want = line_status_q.pop_front();
        got  = i2cbl_pkg::i2cbl_res_t'(out_tdata[$bits(i2cbl_pkg::i2cbl_res_t)-1:0]);
        check_field("scl_level", want.scl_level, got.scl_level);
        check_field("sda_level", want.sda_level, got.sda_level);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("done_res", want.done_res, got.done_res);
        check_field("rx_byte", want.rx_byte, got.rx_byte);
        check_field("ack_ok", want.ack_ok, got.ack_ok);
        check_field("start_error", want.start_error, got.start_error);
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    step_t row;
    i2cbl_pkg::i2cbl_res_t r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed steps
    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      if (row.cfg_pre >= 0) write_ptick(i2cbl_pkg::PTICK_W'(row.cfg_pre));
      run_command(row.act, row.db, row.mode, row.cfg_mid);
      if (row.typed != EXP_PREDICT) begin
        r = line_status_q.pop_back();
        if (row.typed == EXP_IDLE) begin
          r.scl_level = 1'b1;
          r.sda_level = 1'b1;
        end
        r.busy_res    = 1'b0;
        r.done_res    = (row.typed == EXP_DONE);
        r.rx_byte     = row.rx;
        r.ack_ok      = row.ack;
        r.start_error = row.serr;
        line_status_q.push_back(r);
      end
    end

    // random traffic under each idling pattern
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = idle_tab[p];
      sink_stall_pct = stall_tab[p];
      write_ptick(i2cbl_pkg::PTICK_W'(len_tab[p]));
      random_traffic(25);
    end

    // let the last results drain
    in_tvalid <= 1'b0;
    while (line_status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
